// ===== design/psls_pkg.sv =====
// ----------------------------------------------------------------------------
// psls_pkg
// Shared types and constants for the packet sequence loss statistics block.
// ----------------------------------------------------------------------------
package psls_pkg;

  // Header checks and rate scaling
  localparam logic [15:0] MIN_LEN   = 16'd20;
  localparam int          US_W      = 20;
  localparam logic [US_W-1:0] US_PER_S = 20'd1000000;
  localparam int          PROD_W    = 32 + US_W;
  localparam int          CNT_W     = $clog2(PROD_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC    = 3'd0,
    CFG_VERSION  = 3'd1,
    CFG_CODE_DATA  = 3'd2,
    CFG_CODE_DONE  = 3'd3,
    CFG_CODE_TX    = 3'd4,
    CFG_CODE_RESET = 3'd5
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_REPORT    = 3'd2,
    ST_RESET     = 3'd3,
    ST_TX_START  = 3'd4
  } status_t;

  // Top-level sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV_START,
    S_DIV_WAIT,
    S_OUT
  } state_t;

  // One received packet header
  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] pkt_type;
    logic [31:0] seq;
    logic [31:0] declared_len;
    logic [15:0] packet_len;
    logic [31:0] now_us;
  } item_t;

  // Counters reported with every result
  typedef struct packed {
    status_t     status;
    logic [31:0] pkts;
    logic [31:0] bytes_total;
    logic [31:0] missing;
    logic [31:0] malformed;
    logic [31:0] reordered;
    logic [31:0] elapsed;
  } stats_t;

endpackage

// ===== design/psls_stats.sv =====
// ----------------------------------------------------------------------------
// psls_stats
// Configuration registers, header check and receive statistics update.
// ----------------------------------------------------------------------------
module psls_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [psls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          upd,
  input  psls_pkg::item_t               item,
  output psls_pkg::stats_t              stats
);

  logic [31:0] exp_magic;
  logic [15:0] exp_version;
  logic [15:0] code_data;
  logic [15:0] code_done;
  logic [15:0] code_tx;
  logic [15:0] code_reset;

  logic [31:0] pkts, pkts_next;
  logic [31:0] bytes_total, bytes_total_next;
  logic [31:0] missing, missing_next;
  logic [31:0] malformed, malformed_next;
  logic [31:0] reordered, reordered_next;
  logic [31:0] next_expected, next_expected_next;
  logic [31:0] first_time, first_time_next;
  logic [31:0] last_time, last_time_next;
  logic        started, started_next;
  psls_pkg::status_t status, status_next;

  logic        bad_hdr;
  logic [31:0] gap;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_magic   <= 32'd0;
      exp_version <= 16'd1;
      code_data   <= 16'd1;
      code_done   <= 16'd2;
      code_tx     <= 16'd3;
      code_reset  <= 16'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psls_pkg::CFG_MAGIC:      exp_magic   <= cfg_data;
        psls_pkg::CFG_VERSION:    exp_version <= cfg_data[15:0];
        psls_pkg::CFG_CODE_DATA:  code_data   <= cfg_data[15:0];
        psls_pkg::CFG_CODE_DONE:  code_done   <= cfg_data[15:0];
        psls_pkg::CFG_CODE_TX:    code_tx     <= cfg_data[15:0];
        psls_pkg::CFG_CODE_RESET: code_reset  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Check the header against the configured values
  assign bad_hdr = (item.packet_len < psls_pkg::MIN_LEN) ||
                   (item.magic != exp_magic) ||
                   (item.version != exp_version) ||
                   (item.declared_len != {16'd0, item.packet_len});

  // Decode the packet type and work out the new statistics
  always_comb begin
    pkts_next          = pkts;
    bytes_total_next   = bytes_total;
    missing_next       = missing;
    malformed_next     = malformed;
    reordered_next     = reordered;
    next_expected_next = next_expected;
    first_time_next    = first_time;
    last_time_next     = last_time;
    started_next       = started;
    status_next        = psls_pkg::ST_MALFORMED;
    gap                = 32'd0;

    if (bad_hdr) begin
      malformed_next = malformed + 32'd1;
    end else if (item.pkt_type == code_data) begin
      status_next = psls_pkg::ST_DATA;
      // sequence zero restarts the whole measurement
      if (item.seq == 32'd0) begin
        pkts_next          = 32'd0;
        bytes_total_next   = 32'd0;
        missing_next       = 32'd0;
        malformed_next     = 32'd0;
        reordered_next     = 32'd0;
        next_expected_next = 32'd0;
        first_time_next    = 32'd0;
        started_next       = 1'b0;
      end
      gap = item.seq - next_expected_next;
      if (!started_next) begin
        started_next       = 1'b1;
        first_time_next    = item.now_us;
        next_expected_next = item.seq + 32'd1;
      end else if (gap == 32'd0) begin
        next_expected_next = next_expected_next + 32'd1;
      end else if (!gap[31]) begin
        missing_next       = missing_next + gap;
        next_expected_next = item.seq + 32'd1;
      end else begin
        reordered_next = reordered_next + 32'd1;
      end
      last_time_next   = item.now_us;
      pkts_next        = pkts_next + 32'd1;
      bytes_total_next = bytes_total_next + {16'd0, item.packet_len};
    end else if (item.pkt_type == code_done) begin
      status_next = psls_pkg::ST_REPORT;
    end else if (item.pkt_type == code_tx) begin
      status_next = psls_pkg::ST_TX_START;
    end else if (item.pkt_type == code_reset) begin
      status_next        = psls_pkg::ST_RESET;
      pkts_next          = 32'd0;
      bytes_total_next   = 32'd0;
      missing_next       = 32'd0;
      malformed_next     = 32'd0;
      reordered_next     = 32'd0;
      next_expected_next = 32'd0;
      first_time_next    = 32'd0;
      last_time_next     = 32'd0;
      started_next       = 1'b0;
    end else begin
      malformed_next = malformed + 32'd1;
    end
  end

  // Commit the update for one transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      pkts          <= 32'd0;
      bytes_total   <= 32'd0;
      missing       <= 32'd0;
      malformed     <= 32'd0;
      reordered     <= 32'd0;
      next_expected <= 32'd0;
      first_time    <= 32'd0;
      last_time     <= 32'd0;
      started       <= 1'b0;
      status        <= psls_pkg::ST_DATA;
    end else if (upd) begin
      pkts          <= pkts_next;
      bytes_total   <= bytes_total_next;
      missing       <= missing_next;
      malformed     <= malformed_next;
      reordered     <= reordered_next;
      next_expected <= next_expected_next;
      first_time    <= first_time_next;
      last_time     <= last_time_next;
      started       <= started_next;
      status        <= status_next;
    end
  end

  // Report the current counters
  assign stats.status      = status;
  assign stats.pkts        = pkts;
  assign stats.bytes_total = bytes_total;
  assign stats.missing     = missing;
  assign stats.malformed   = malformed;
  assign stats.reordered   = reordered;
  assign stats.elapsed     = started ? (last_time - first_time) : 32'd0;

endmodule

// ===== design/psls_div.sv =====
// ----------------------------------------------------------------------------
// psls_div
// Byte rate unit: scales the byte count to microseconds and divides it by the
// elapsed time with a shared restoring subtractor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module psls_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] bytes_total,
  input  logic [31:0] elapsed,
  output logic        done,
  output logic [31:0] rate
);

  logic [psls_pkg::PROD_W-1:0] dvd;
  logic [31:0]                 rem;
  logic [psls_pkg::CNT_W-1:0]  cnt;
  logic [32:0]                 rem_sh;
  logic [33:0]                 diff;
  logic                        ge;

  // Shift in the next dividend bit and trial subtract
  assign rem_sh = {rem, dvd[psls_pkg::PROD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, elapsed};
  assign ge     = !diff[33];

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (elapsed == 32'd0) begin
          cnt  <= '0;
          done <= 1'b1;
        end else begin
          cnt <= psls_pkg::DIV_STEPS;
        end
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == psls_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Hold dividend, remainder and quotient; keep the low quotient bits only
  always_ff @(posedge clk) begin
    if (start) begin
      dvd  <= psls_pkg::PROD_W'(bytes_total) * psls_pkg::PROD_W'(psls_pkg::US_PER_S);
      rem  <= 32'd0;
      rate <= 32'd0;
    end else if (cnt != '0) begin
      dvd  <= {dvd[psls_pkg::PROD_W-2:0], 1'b0};
      rem  <= ge ? diff[31:0] : rem_sh[31:0];
      rate <= {rate[30:0], ge};
    end
  end

endmodule

// ===== design/packet_sequence_loss_stats.sv =====
// ----------------------------------------------------------------------------
// packet_sequence_loss_stats
// Receive statistics for a sequence-numbered test packet stream.
// ----------------------------------------------------------------------------
// One packet header is taken at a time. An accepted transaction passes through
// the header check and counter update, the loading of the rate unit, and then
// the rate divider, which produces one quotient bit per cycle of the 52-bit
// scaled byte count (it finishes at once when the elapsed time is zero); the
// result is offered the cycle after, and in_ready returns once the result is
// taken. Configuration writes go to index 0..5 in the order magic, version,
// data, done, transmit start and reset code; other indexes are ignored.
// ----------------------------------------------------------------------------
module packet_sequence_loss_stats (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] magic,
  input  logic [15:0] version,
  input  logic [15:0] pkt_type,
  input  logic [31:0] seq,
  input  logic [31:0] declared_len,
  input  logic [15:0] packet_len,
  input  logic [31:0] now_us,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] packet_total,
  output logic [31:0] byte_count,
  output logic [31:0] missing_count,
  output logic [31:0] malformed_count,
  output logic [31:0] reorder_count,
  output logic [31:0] elapsed_time,
  output logic [31:0] rate_bps
);

  psls_pkg::state_t state, state_next;
  psls_pkg::item_t  item;
  psls_pkg::stats_t stats;
  logic             upd;
  logic             div_start;
  logic             div_done;

  // Hold the accepted header
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.magic        <= magic;
      item.version      <= version;
      item.pkt_type     <= pkt_type;
      item.seq          <= seq;
      item.declared_len <= declared_len;
      item.packet_len   <= packet_len;
      item.now_us       <= now_us;
    end
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psls_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    upd        = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      psls_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = psls_pkg::S_UPDATE;
        end
      end
      psls_pkg::S_UPDATE: begin
        upd        = 1'b1;
        state_next = psls_pkg::S_DIV_START;
      end
      psls_pkg::S_DIV_START: begin
        div_start  = 1'b1;
        state_next = psls_pkg::S_DIV_WAIT;
      end
      psls_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          state_next = psls_pkg::S_OUT;
        end
      end
      psls_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = psls_pkg::S_IDLE;
        end
      end
      default: state_next = psls_pkg::S_IDLE;
    endcase
  end

  psls_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .upd       (upd),
    .item      (item),
    .stats     (stats)
  );

  psls_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .bytes_total (stats.bytes_total),
    .elapsed     (stats.elapsed),
    .done        (div_done),
    .rate        (rate_bps)
  );

  // Drive the result from the held counters
  assign status          = stats.status;
  assign packet_total    = stats.pkts;
  assign byte_count      = stats.bytes_total;
  assign missing_count   = stats.missing;
  assign malformed_count = stats.malformed;
  assign reorder_count   = stats.reordered;
  assign elapsed_time    = stats.elapsed;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the packet sequence loss statistics block against a cycle-free
// prediction of its counters. Directed headers cover the length, magic,
// version and declared-length checks, unknown type codes, sequence gaps,
// late packets, sequence-zero clears and time wrap. Random phases under varying
// flow control and register settings, coinciding type codes among them, follow.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MIN_PKT_LEN    = 20;
  localparam bit [63:0]   US_PER_SEC     = 64'd1000000;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          TAIL_CYCLES    = 120;
  localparam int          PHASE_ITEMS    = 410;
  // Indexes past the last register; writes there must have no effect
  localparam logic [2:0]  CFG_UNUSED_LO  = 3'd6;
  localparam logic [2:0]  CFG_UNUSED_HI  = 3'd7;

  typedef struct packed {
    psls_pkg::status_t status;
    logic [31:0] pkts;
    logic [31:0] bytes_total;
    logic [31:0] missing;
    logic [31:0] malformed;
    logic [31:0] reordered;
    logic [31:0] elapsed;
    logic [31:0] rate;
  } loss_report_t;

  // Receive statistics tracker: predicts one report per accepted header
  class rx_stats_tracker;
    bit [31:0] magic_word;
    bit [15:0] version_word;
    bit [15:0] code_data;
    bit [15:0] code_done;
    bit [15:0] code_tx;
    bit [15:0] code_reset;

    bit [31:0] pkt_total;
    bit [31:0] byte_total;
    bit [31:0] missing_total;
    bit [31:0] malformed_total;
    bit [31:0] reorder_total;
    bit [31:0] next_seq;
    bit [31:0] first_us;
    bit [31:0] last_us;
    bit        started;

    int errors;
    loss_report_t expected_reports[$];

    function new();
      magic_word   = 32'd0;
      version_word = 16'd1;
      code_data    = 16'd1;
      code_done    = 16'd2;
      code_tx      = 16'd3;
      code_reset   = 16'd4;
      errors       = 0;
      clear_counters();
    endfunction

    function void clear_counters();
      pkt_total       = 0;
      byte_total      = 0;
      missing_total   = 0;
      malformed_total = 0;
      reorder_total   = 0;
      next_seq        = 0;
      first_us        = 0;
      last_us         = 0;
      started         = 1'b0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        psls_pkg::CFG_MAGIC:      magic_word   = data;
        psls_pkg::CFG_VERSION:    version_word = data[15:0];
        psls_pkg::CFG_CODE_DATA:  code_data    = data[15:0];
        psls_pkg::CFG_CODE_DONE:  code_done    = data[15:0];
        psls_pkg::CFG_CODE_TX:    code_tx      = data[15:0];
        psls_pkg::CFG_CODE_RESET: code_reset   = data[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Update the counters for one accepted header and queue its report
    function void note_packet(psls_pkg::item_t p);
      loss_report_t r;
      bit [31:0]    gap;
      if (p.packet_len < MIN_PKT_LEN || p.magic != magic_word ||
          p.version != version_word || p.declared_len != {16'd0, p.packet_len}) begin
        malformed_total++;
        r.status = psls_pkg::ST_MALFORMED;
      end else if (p.pkt_type == code_data) begin
        if (p.seq == 32'd0) clear_counters();
        if (!started) begin
          started  = 1'b1;
          first_us = p.now_us;
          next_seq = p.seq + 32'd1;
        end else begin
          gap = p.seq - next_seq;
          if (gap == 32'd0) begin
            next_seq++;
          end else if (gap < 32'h8000_0000) begin
            missing_total += gap;
            next_seq = p.seq + 32'd1;
          end else begin
            reorder_total++;
          end
        end
        last_us = p.now_us;
        pkt_total++;
        byte_total += {16'd0, p.packet_len};
        r.status = psls_pkg::ST_DATA;
      end else if (p.pkt_type == code_done) begin
        r.status = psls_pkg::ST_REPORT;
      end else if (p.pkt_type == code_tx) begin
        r.status = psls_pkg::ST_TX_START;
      end else if (p.pkt_type == code_reset) begin
        clear_counters();
        r.status = psls_pkg::ST_RESET;
      end else begin
        malformed_total++;
        r.status = psls_pkg::ST_MALFORMED;
      end

      r.pkts        = pkt_total;
      r.bytes_total = byte_total;
      r.missing     = missing_total;
      r.malformed   = malformed_total;
      r.reordered   = reorder_total;
      r.elapsed     = started ? last_us - first_us : 32'd0;
      if (r.elapsed != 32'd0)
        r.rate = 32'((64'(byte_total) * US_PER_SEC) / 64'(r.elapsed));
      else
        r.rate = 32'd0;
      expected_reports.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one delivered report with the oldest prediction
    function void check_report(loss_report_t got);
      loss_report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual status %0d packets %0h",
                 $time, got.status, got.pkts);
        return;
      end
      want = expected_reports.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("packet_total", want.pkts, got.pkts);
      compare_field("byte_count", want.bytes_total, got.bytes_total);
      compare_field("missing_count", want.missing, got.missing);
      compare_field("malformed_count", want.malformed, got.malformed);
      compare_field("reorder_count", want.reordered, got.reordered);
      compare_field("elapsed_time", want.elapsed, got.elapsed);
      compare_field("rate_bps", want.rate, got.rate);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] magic = 32'd0;
  logic [15:0] version = 16'd0;
  logic [15:0] pkt_type = 16'd0;
  logic [31:0] seq = 32'd0;
  logic [31:0] declared_len = 32'd0;
  logic [15:0] packet_len = 16'd0;
  logic [31:0] now_us = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] packet_total;
  logic [31:0] byte_count;
  logic [31:0] missing_count;
  logic [31:0] malformed_count;
  logic [31:0] reorder_count;
  logic [31:0] elapsed_time;
  logic [31:0] rate_bps;

  rx_stats_tracker sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     rcv_idle_pct = 0;
  int              stall_cycles = 0;
  bit [31:0]       clock_us = 32'd0;
  bit [31:0]       code_a;
  psls_pkg::item_t hdr;
  loss_report_t    seen;

  packet_sequence_loss_stats DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .magic           (magic),
    .version         (version),
    .pkt_type        (pkt_type),
    .seq             (seq),
    .declared_len    (declared_len),
    .packet_len      (packet_len),
    .now_us          (now_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .packet_total    (packet_total),
    .byte_count      (byte_count),
    .missing_count   (missing_count),
    .malformed_count (malformed_count),
    .reorder_count   (reorder_count),
    .elapsed_time    (elapsed_time),
    .rate_bps        (rate_bps)
  );

  always #1 clk = ~clk;

  // Stall the result channel at random
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= rcv_idle_pct);
  end

  // Check delivered reports and watch for a hung handshake
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.status      = psls_pkg::status_t'(status);
        seen.pkts        = packet_total;
        seen.bytes_total = byte_count;
        seen.missing     = missing_count;
        seen.malformed   = malformed_count;
        seen.reordered   = reorder_count;
        seen.elapsed     = elapsed_time;
        seen.rate        = rate_bps;
        sb.check_report(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one header, optionally after a gap, and hold it until accepted
  task automatic send_packet(input psls_pkg::item_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1))
        @(negedge clk);
    end
    {magic, version, pkt_type, seq, declared_len, packet_len, now_us} = p;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_packet(p);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Drop valid and wait for every outstanding report
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Well-formed header under the current register settings
  function automatic psls_pkg::item_t good(bit [15:0] kind, bit [31:0] s, bit [15:0] len,
                                           bit [31:0] t);
    psls_pkg::item_t p;
    p.magic        = sb.magic_word;
    p.version      = sb.version_word;
    p.pkt_type     = kind;
    p.seq          = s;
    p.declared_len = {16'd0, len};
    p.packet_len   = len;
    p.now_us       = t;
    return p;
  endfunction

  // Mostly valid data traffic with gaps and late packets, plus noise
  function automatic psls_pkg::item_t make_random_packet();
    psls_pkg::item_t p;
    int unsigned     pick;
    int unsigned     sub;
    bit [15:0]       len;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if ($urandom_range(49) == 0)
      clock_us = $urandom;
    else
      clock_us += $urandom_range(5000, 1);
    if ($urandom_range(9) == 0)
      len = 16'($urandom_range(65535, MIN_PKT_LEN));
    else
      len = 16'($urandom_range(1500, MIN_PKT_LEN));
    p = good(sb.code_data, $urandom, len, clock_us);

    if (pick < 60) begin
      if (sub < 70)      p.seq = sb.next_seq;
      else if (sub < 82) p.seq = sb.next_seq + $urandom_range(6, 1);
      else if (sub < 90) p.seq = sb.next_seq - $urandom_range(8, 1);
      else if (sub < 94) p.seq = $urandom;
      else if (sub < 96) p.seq = 32'd0;
      else if (sub < 98) p.seq = sb.next_seq + 32'h7FFF_FFFF;
      else               p.seq = sb.next_seq + 32'h8000_0000;
    end else if (pick < 67) begin
      p.pkt_type = sb.code_done;
    end else if (pick < 72) begin
      p.pkt_type = sb.code_tx;
    end else if (pick < 75) begin
      p.pkt_type = sb.code_reset;
    end else if (pick < 80) begin
      p.pkt_type = 16'($urandom);
    end else begin
      // break one header check, on a data type or a random type
      p.pkt_type = (sub < 50) ? sb.code_data : 16'($urandom);
      case ($urandom_range(3))
        0: begin
          p.packet_len   = 16'($urandom_range(MIN_PKT_LEN - 1, 0));
          p.declared_len = {16'd0, p.packet_len};
        end
        1: p.magic = (sub < 50) ? $urandom : sb.magic_word ^ (32'd1 << $urandom_range(31));
        2: p.version = (sub < 50) ? 16'($urandom) : sb.version_word ^ (16'd1 << $urandom_range(15));
        default: p.declared_len = (sub < 50) ? $urandom
                                             : p.declared_len ^ (32'd1 << $urandom_range(31));
      endcase
    end
    return p;
  endfunction

  task automatic run_random(input int n);
    repeat (n) send_packet(make_random_packet());
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 19;
    rcv_idle_pct  = 48;

    // Directed headers under the reset register values
    send_packet(good(sb.code_done, 32'd0, 16'd20, 32'd0));
    send_packet(good(sb.code_data, 32'd5, 16'd20, 32'd100));
    send_packet(good(sb.code_data, 32'd6, 16'hFFFF, 32'd1100));
    send_packet(good(sb.code_data, 32'd10, 16'd64, 32'd2000));
    send_packet(good(sb.code_data, 32'd8, 16'd64, 32'd2100));
    send_packet(good(sb.code_data, sb.next_seq + 32'h7FFF_FFFF, 16'd100, 32'd2200));
    send_packet(good(sb.code_data, sb.next_seq + 32'h8000_0000, 16'd100, 32'd2300));
    hdr = good(sb.code_data, sb.next_seq, 16'd19, 32'd2400);
    send_packet(hdr);
    hdr = good(sb.code_data, sb.next_seq, 16'd100, 32'd2500);
    hdr.magic = 32'hFFFF_FFFF;
    send_packet(hdr);
    hdr = good(sb.code_data, sb.next_seq, 16'd100, 32'd2600);
    hdr.version = 16'd0;
    send_packet(hdr);
    hdr.version = 16'hFFFF;
    send_packet(hdr);
    hdr = good(sb.code_data, sb.next_seq, 16'd100, 32'd2700);
    hdr.declared_len = 32'hFFFF_FFFF;
    send_packet(hdr);
    hdr.declared_len = 32'h0001_0064;
    send_packet(hdr);
    send_packet(good(16'hFFFF, 32'd7, 16'd40, 32'd2800));
    send_packet(good(sb.code_tx, 32'hFFFF_FFFF, 16'd40, 32'd2900));
    send_packet(good(sb.code_done, 32'd0, 16'd40, 32'd3000));
    // sequence zero clears everything, then the time stamps wrap
    send_packet(good(sb.code_data, 32'd0, 16'd1000, 32'hFFFF_FFF0));
    send_packet(good(sb.code_data, 32'd1, 16'd1000, 32'h0000_0010));
    send_packet(good(sb.code_data, 32'd2, 16'hFFFF, 32'h0000_0011));
    send_packet(good(sb.code_reset, 32'd3, 16'd20, 32'd50));
    send_packet(good(sb.code_done, 32'd3, 16'd20, 32'd60));
    send_packet(good(sb.code_data, 32'hFFFF_FFFF, 16'd500, 32'd500));
    send_packet(good(sb.code_data, 32'd0, 16'hFFFF, 32'd600));
    // one microsecond apart: the rate overflows 32 bits
    send_packet(good(sb.code_data, 32'd1, 16'hFFFF, 32'd601));
    run_random(PHASE_ITEMS);

    // Extreme register values, upper bits set on some of the narrow registers
    send_idle_pct = 48;
    rcv_idle_pct  = 19;
    write_reg(psls_pkg::CFG_MAGIC, 32'hFFFF_FFFF);
    write_reg(psls_pkg::CFG_VERSION, 32'hA5A5_FFFF);
    write_reg(psls_pkg::CFG_CODE_DATA, 32'hFFFF_0000);
    write_reg(psls_pkg::CFG_CODE_DONE, 32'h0000_FFFF);
    write_reg(psls_pkg::CFG_CODE_TX, 32'h1234_8000);
    write_reg(psls_pkg::CFG_CODE_RESET, 32'h0000_7FFF);
    write_reg(CFG_UNUSED_LO, $urandom);
    write_reg(CFG_UNUSED_HI, 32'hFFFF_FFFF);
    run_random(PHASE_ITEMS);

    // Random register values, no flow-control idling
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    write_reg(psls_pkg::CFG_MAGIC, $urandom);
    write_reg(psls_pkg::CFG_VERSION, $urandom);
    write_reg(psls_pkg::CFG_CODE_DATA, $urandom);
    write_reg(psls_pkg::CFG_CODE_DONE, $urandom);
    write_reg(psls_pkg::CFG_CODE_TX, $urandom);
    write_reg(psls_pkg::CFG_CODE_RESET, $urandom);
    run_random(PHASE_ITEMS);

    // Coinciding codes: data shadows done, transmit start shadows reset
    code_a = $urandom;
    write_reg(psls_pkg::CFG_MAGIC, 32'd0);
    write_reg(psls_pkg::CFG_VERSION, 32'd0);
    write_reg(psls_pkg::CFG_CODE_DATA, code_a);
    write_reg(psls_pkg::CFG_CODE_DONE, code_a);
    write_reg(psls_pkg::CFG_CODE_TX, ~code_a);
    write_reg(psls_pkg::CFG_CODE_RESET, ~code_a);
    run_random(PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
